// ===== rtl/tsbfh_pkg.sv =====
// Shared constants for the two-stack navigation history block.
// Field widths, command codes and status codes; no dependencies.
package tsbfh_pkg;

    localparam int FUNC_W   = 2;
    localparam int PAGE_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_VISIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BACK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FORWARD = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

// ===== rtl/tsbfh_req_if.sv =====
// Request channel of the navigation history: valid/ready plus command payload.
// Depends on tsbfh_pkg.
interface tsbfh_req_if;
    import tsbfh_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [PAGE_W-1:0] page_id;

    modport source (output valid, func, page_id, input ready);
    modport sink   (input valid, func, page_id, output ready);
endinterface

// ===== rtl/tsbfh_rsp_if.sv =====
// Result channel of the navigation history: valid/ready plus status and page.
// Depends on tsbfh_pkg.
interface tsbfh_rsp_if;
    import tsbfh_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   current_page;

    modport source (output valid, status, current_page, input ready);
    modport sink   (input valid, status, current_page, output ready);
endinterface

// ===== rtl/two_stack_back_forward_history.sv =====
// Back/forward navigation history built on two stack memories.
// Depends on tsbfh_pkg, tsbfh_req_if and tsbfh_rsp_if.
//
// Each request (visit, back, forward) gives one result: a status and the
// current page afterwards. The back stack and forward stack each sit in a
// single-port-write, registered-read memory; entry zero of the back stack is
// the home_page register, so home changes show at once. A visit, and any
// ignored or overflowing request, has its result registered in the cycle
// after acceptance; a successful back or forward first waits in S_BACK_RD
// or S_FWD_RD, because the new current page comes from the registered read
// of a stack memory. The next request is taken once no such read is pending
// and the result register is free or being drained. No clearing pass is
// needed after reset.
module two_stack_back_forward_history #(
    parameter int STACK_DEPTH = 128,
    parameter int PAGE_WIDTH  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tsbfh_pkg::PAGE_W-1:0] i_cfg_wdata,
    tsbfh_req_if.sink                 i_req,
    tsbfh_rsp_if.source               o_rsp
);
    import tsbfh_pkg::*;

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [IDX_W-1:0] TOP_FULL = IDX_W'(STACK_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_ZERO = '0;

    typedef enum logic [1:0] {S_IDLE, S_BACK_RD, S_FWD_RD} t_state;

    function automatic logic [PAGE_WIDTH-1:0] to_page(input logic [PAGE_W-1:0] v);
        logic [127:0] w;
        w = 128'(v);
        return w[PAGE_WIDTH-1:0];
    endfunction

    function automatic logic [PAGE_W-1:0] to_port(input logic [PAGE_WIDTH-1:0] v);
        logic [127:0] w;
        w = 128'(v);
        return w[PAGE_W-1:0];
    endfunction

    logic [PAGE_WIDTH-1:0] back_mem [STACK_DEPTH];
    logic [PAGE_WIDTH-1:0] fwd_mem  [STACK_DEPTH];

    t_state                r_state;
    logic [IDX_W-1:0]      r_top;
    logic [IDX_W-1:0]      r_fcnt;
    logic [PAGE_WIDTH-1:0] r_cur;
    logic [PAGE_W-1:0]     r_home;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [PAGE_WIDTH-1:0] r_out_page;
    logic [PAGE_WIDTH-1:0] r_back_rdata;
    logic [PAGE_WIDTH-1:0] r_fwd_rdata;

    logic                  accept;
    logic [PAGE_WIDTH-1:0] home_page;
    logic [PAGE_WIDTH-1:0] cur_page;
    logic                  back_we;
    logic [IDX_W-1:0]      back_wa;
    logic [PAGE_WIDTH-1:0] back_wd;
    logic                  fwd_we;
    logic                  fwd_go;
    logic                  out_load;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.current_page = to_port(r_out_page);

    assign home_page = to_page(r_home);
    // Bottom of the back stack always reads the home register.
    assign cur_page  = (r_top == IDX_ZERO) ? home_page : r_cur;

    // Forward stack push on a successful back.
    assign fwd_we = accept && (i_req.func == FUNC_BACK) && (r_top != IDX_ZERO);
    assign fwd_go = accept && (i_req.func == FUNC_FORWARD) && (r_fcnt != IDX_ZERO)
                    && (r_top != TOP_FULL);
    // result loads now unless a back or forward still waits on its memory read
    assign out_load = (accept && !fwd_we && !fwd_go) || (r_state == S_BACK_RD)
                      || (r_state == S_FWD_RD);

    always_comb begin
        back_we = 1'b0;
        back_wa = r_top + 1'b1;
        back_wd = to_page(i_req.page_id);
        if (accept && (i_req.func == FUNC_VISIT) && (r_top != TOP_FULL)) begin
            back_we = 1'b1;
        end else if (r_state == S_FWD_RD) begin
            // top was already bumped when the forward request was taken
            back_we = 1'b1;
            back_wa = r_top;
            back_wd = r_fwd_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_we) begin
            back_mem[back_wa] <= back_wd;
        end
        r_back_rdata <= back_mem[r_top - 1'b1];
    end

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            fwd_mem[r_fcnt] <= cur_page;
        end
        r_fwd_rdata <= fwd_mem[r_fcnt - 1'b1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_top        <= '0;
            r_fcnt       <= '0;
            r_home       <= '0;
            r_out_valid  <= 1'b0;
            r_out_status <= ST_DONE;
            r_out_page   <= '0;
            r_cur        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_home <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        priority if (i_req.func == FUNC_VISIT) begin
                            if (r_top == TOP_FULL) begin
                                r_out_status <= ST_OVERFLOW;
                                r_out_page   <= cur_page;
                            end else begin
                                r_top        <= r_top + 1'b1;
                                r_fcnt       <= '0;
                                r_cur        <= to_page(i_req.page_id);
                                r_out_status <= ST_DONE;
                                r_out_page   <= to_page(i_req.page_id);
                            end
                        end else if (i_req.func == FUNC_BACK) begin
                            if (r_top == IDX_ZERO) begin
                                r_out_status <= ST_IGNORED;
                                r_out_page   <= cur_page;
                            end else begin
                                r_top   <= r_top - 1'b1;
                                r_fcnt  <= r_fcnt + 1'b1;
                                r_state <= S_BACK_RD;
                            end
                        end else if (i_req.func == FUNC_FORWARD) begin
                            if (r_fcnt == IDX_ZERO) begin
                                r_out_status <= ST_IGNORED;
                                r_out_page   <= cur_page;
                            end else if (r_top == TOP_FULL) begin
                                r_out_status <= ST_OVERFLOW;
                                r_out_page   <= cur_page;
                            end else begin
                                r_top   <= r_top + 1'b1;
                                r_fcnt  <= r_fcnt - 1'b1;
                                r_state <= S_FWD_RD;
                            end
                        end else begin
                            r_out_status <= ST_IGNORED;
                            r_out_page   <= cur_page;
                        end
                    end
                end
                S_BACK_RD: begin
                    r_cur        <= r_back_rdata;
                    r_out_status <= ST_DONE;
                    r_out_page   <= (r_top == IDX_ZERO) ? home_page : r_back_rdata;
                    r_state      <= S_IDLE;
                end
                S_FWD_RD: begin
                    r_cur        <= r_fwd_rdata;
                    r_out_status <= ST_DONE;
                    r_out_page   <= r_fwd_rdata;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for two_stack_back_forward_history: directed table, then random mix.
// Depends on tsbfh_pkg, tsbfh_req_if, tsbfh_rsp_if and the block itself.
module tb;
    import tsbfh_pkg::*;

    localparam int DEPTH     = 128;
    localparam int MAX_CYC   = 400000;
    localparam int HOLD_CYC  = 250;
    localparam int DIR_ROWS  = 22;
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
    } t_nav_result;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [PAGE_W-1:0]   page_id;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [PAGE_W-1:0] cfg_wdata;

    tsbfh_req_if req_if ();
    tsbfh_rsp_if rsp_if ();

    two_stack_back_forward_history #(
        .STACK_DEPTH(DEPTH),
        .PAGE_WIDTH (PAGE_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // history model
    logic [PAGE_W-1:0] hist_back [DEPTH];
    logic [PAGE_W-1:0] hist_fwd  [DEPTH];
    int unsigned       back_top;
    int unsigned       fwd_count;
    logic [PAGE_W-1:0] home_reg;

    t_nav_result expected_results [$];
    int          err_count;
    int          cycle_count;
    bit          gaps_on;
    bit          hold_req;
    t_dir_row    dir_tab [DIR_ROWS];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_nav_result nav_apply(input logic [FUNC_W-1:0] f,
                                              input logic [PAGE_W-1:0] p);
        t_nav_result r;
        r.status = ST_IGNORED;
        case (f)
            FUNC_VISIT: begin
                if (back_top >= DEPTH - 1) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    back_top++;
                    hist_back[back_top] = p;
                    fwd_count = 0;
                    r.status = ST_DONE;
                end
            end
            FUNC_BACK: begin
                if (back_top == 0) begin
                    r.status = ST_IGNORED;
                end else if (fwd_count >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    hist_fwd[fwd_count] = hist_back[back_top];
                    fwd_count++;
                    back_top--;
                    r.status = ST_DONE;
                end
            end
            FUNC_FORWARD: begin
                if (fwd_count == 0) begin
                    r.status = ST_IGNORED;
                end else if (back_top >= DEPTH - 1) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    fwd_count--;
                    back_top++;
                    hist_back[back_top] = hist_fwd[fwd_count];
                    r.status = ST_DONE;
                end
            end
            default: r.status = ST_IGNORED;
        endcase
        // entry zero always reads the home register
        r.page = (back_top == 0) ? home_reg : hist_back[back_top];
        return r;
    endfunction

    task automatic log_error(input string msg);
        if (err_count < 10) $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic send_req(input logic [FUNC_W-1:0] f, input logic [PAGE_W-1:0] p,
                            input logic typed, input t_nav_result typed_res);
        t_nav_result r;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= f;
        req_if.page_id <= p;
        do @(posedge i_clk); while (!req_if.ready);
        r = nav_apply(f, p);
        expected_results.push_back(typed ? typed_res : r);
    endtask

    task automatic run_mix(input int n, input int w_visit, input int w_back);
        int                r;
        logic [FUNC_W-1:0] f;
        logic [PAGE_W-1:0] p;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < w_visit)               f = FUNC_VISIT;
            else if (r < w_visit + w_back) f = FUNC_BACK;
            else if (r < 97)               f = FUNC_FORWARD;
            else                           f = FUNC_UNKNOWN;
            case ($urandom_range(0, 7))
                0:       p = '0;
                1:       p = '1;
                default: p = $urandom;
            endcase
            send_req(f, p, 1'b0, '0);
        end
    endtask

    task automatic run_same(input int n, input logic [FUNC_W-1:0] f);
        for (int i = 0; i < n; i++) send_req(f, $urandom, 1'b0, '0);
    endtask

    // drain every pending request, then write the home page register
    task automatic set_home(input logic [PAGE_W-1:0] v);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        home_reg = v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_nav_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                log_error($sformatf("unexpected result status=%0d page=%h",
                                    rsp_if.status, rsp_if.current_page));
            end else begin
                want = expected_results.pop_front();
                if (rsp_if.status !== want.status)
                    log_error($sformatf("status exp=%0d act=%0d",
                                        want.status, rsp_if.status));
                if (rsp_if.current_page !== want.page)
                    log_error($sformatf("current_page exp=%h act=%h",
                                        want.page, rsp_if.current_page));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYC) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_if.valid   = 1'b0;
        req_if.func    = FUNC_VISIT;
        req_if.page_id = '0;
        err_count      = 0;
        cycle_count    = 0;
        gaps_on        = 1'b1;
        hold_req       = 1'b0;
        back_top       = 0;
        fwd_count      = 0;
        home_reg       = '0;

        // home page is zero out of reset
        dir_tab = '{
            '{FUNC_BACK,    32'h0000_0000, 1'b1, ST_IGNORED, 32'h0000_0000},
            '{FUNC_FORWARD, 32'h0000_0000, 1'b1, ST_IGNORED, 32'h0000_0000},
            '{FUNC_UNKNOWN, 32'hFFFF_FFFF, 1'b1, ST_IGNORED, 32'h0000_0000},
            '{FUNC_VISIT,   32'hFFFF_FFFF, 1'b1, ST_DONE,    32'hFFFF_FFFF},
            '{FUNC_VISIT,   32'h0000_0000, 1'b1, ST_DONE,    32'h0000_0000},
            '{FUNC_VISIT,   32'h8000_0001, 1'b1, ST_DONE,    32'h8000_0001},
            '{FUNC_BACK,    32'hFFFF_FFFF, 1'b1, ST_DONE,    32'h0000_0000},
            '{FUNC_BACK,    32'h0000_0000, 1'b1, ST_DONE,    32'hFFFF_FFFF},
            '{FUNC_BACK,    32'h0000_0000, 1'b1, ST_DONE,    32'h0000_0000},
            '{FUNC_BACK,    32'h0000_0000, 1'b1, ST_IGNORED, 32'h0000_0000},
            '{FUNC_FORWARD, 32'h0000_0000, 1'b1, ST_DONE,    32'hFFFF_FFFF},
            '{FUNC_FORWARD, 32'h0000_0000, 1'b1, ST_DONE,    32'h0000_0000},
            '{FUNC_FORWARD, 32'hFFFF_FFFF, 1'b1, ST_DONE,    32'h8000_0001},
            '{FUNC_FORWARD, 32'h0000_0000, 1'b1, ST_IGNORED, 32'h8000_0001},
            '{FUNC_BACK,    32'h0000_0000, 1'b1, ST_DONE,    32'h0000_0000},
            '{FUNC_VISIT,   32'h7FFF_FFFF, 1'b1, ST_DONE,    32'h7FFF_FFFF},
            '{FUNC_FORWARD, 32'h0000_0000, 1'b1, ST_IGNORED, 32'h7FFF_FFFF},
            '{FUNC_UNKNOWN, 32'h0000_0000, 1'b1, ST_IGNORED, 32'h7FFF_FFFF},
            '{FUNC_VISIT,   32'h1234_5678, 1'b0, ST_DONE,    32'h0000_0000},
            '{FUNC_BACK,    32'h0000_0000, 1'b0, ST_DONE,    32'h0000_0000},
            '{FUNC_BACK,    32'h0000_0000, 1'b0, ST_DONE,    32'h0000_0000},
            '{FUNC_FORWARD, 32'h0000_0000, 1'b0, ST_DONE,    32'h0000_0000}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_req(dir_tab[i].func, dir_tab[i].page_id, dir_tab[i].typed,
                     {dir_tab[i].status, dir_tab[i].page});

        set_home(32'hFFFF_FFFF);
        run_mix(300, 40, 30);

        // long result stall while requests keep coming
        hold_req = 1'b1;
        run_mix(40, 50, 25);

        // fill to overflow, unwind past home, then replay all the way forward
        set_home(32'h0000_0000);
        run_same(135, FUNC_VISIT);
        run_same(135, FUNC_BACK);
        run_same(135, FUNC_FORWARD);
        run_same(3, FUNC_VISIT);

        // home changes under a full history, then walk back toward it
        set_home($urandom);
        run_mix(150, 15, 60);

        set_home($urandom);
        run_mix(300, 45, 30);

        gaps_on = 1'b0;
        set_home(32'h5A5A_0F0F);
        run_mix(200, 40, 30);

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
